[design/ppp_pkg.sv]
// shared types, constants and helpers for the pose point projection block
`default_nettype none
package ppp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS = 8;
	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_K00,
		REG_K01,
		REG_K02,
		REG_K10,
		REG_K11,
		REG_K12,
		REG_SCALE_X,
		REG_SCALE_Y
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] rot_a_x;
		logic signed [31:0] rot_a_y;
		logic signed [31:0] rot_a_z;
		logic signed [31:0] rot_b_x;
		logic signed [31:0] rot_b_y;
		logic signed [31:0] rot_b_z;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} point_word_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic               valid_res;
	} pixel_word_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	typedef struct packed {
		logic zero;
		logic neg_x;
		logic neg_y;
	} div_tag_t;

	typedef struct packed {
		logic signed [31:0] k00;
		logic signed [31:0] k01;
		logic signed [31:0] k02;
		logic signed [31:0] k10;
		logic signed [31:0] k11;
		logic signed [31:0] k12;
		logic [30:0]        scale_x;
		logic [30:0]        scale_y;
	} cam_cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
		logic signed [31:0] r;
		if (x > 72'sd2147483647)
			r = 32'sh7fffffff;
		else if (x < -72'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		logic signed [32:0] n;
		n = -33'(x);
		return x[31] ? n[31:0] : x[31:0];
	endfunction

endpackage
`default_nettype wire

[design/ppp_xform.sv]
// cross product and rigid transform stages
`default_nettype none
module ppp_xform import ppp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire point_word_t in_word,
	output logic             out_valid,
	output vec3_t            out_p
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	point_word_t w_s1, w_s2;
	logic signed [63:0] cp_s1 [6];
	logic signed [31:0] c_s2 [3];
	logic signed [63:0] tp_s3 [3][3];
	logic signed [31:0] t_s3 [3];
	vec3_t p_s4;

	logic signed [64:0] diff [3];
	logic signed [31:0] c_next [3];
	logic signed [31:0] a_v [3];
	logic signed [31:0] b_v [3];
	logic signed [65:0] sum [3];

	always_comb begin
		diff[0] = 65'(cp_s1[0]) - 65'(cp_s1[1]);
		diff[1] = 65'(cp_s1[2]) - 65'(cp_s1[3]);
		diff[2] = 65'(cp_s1[4]) - 65'(cp_s1[5]);
		for (int j = 0; j < 3; j++)
			c_next[j] = sat32(72'(diff[j] >>> FRAC_BITS));
		a_v[0] = w_s2.rot_a_x;
		a_v[1] = w_s2.rot_a_y;
		a_v[2] = w_s2.rot_a_z;
		b_v[0] = w_s2.rot_b_x;
		b_v[1] = w_s2.rot_b_y;
		b_v[2] = w_s2.rot_b_z;
		for (int j = 0; j < 3; j++)
			sum[j] = 66'(tp_s3[j][0] >>> FRAC_BITS) + 66'(tp_s3[j][1] >>> FRAC_BITS)
				+ 66'(tp_s3[j][2] >>> FRAC_BITS) + 66'(t_s3[j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= in_word;
			cp_s1[0] <= in_word.rot_a_y * in_word.rot_b_z;
			cp_s1[1] <= in_word.rot_a_z * in_word.rot_b_y;
			cp_s1[2] <= in_word.rot_a_z * in_word.rot_b_x;
			cp_s1[3] <= in_word.rot_a_x * in_word.rot_b_z;
			cp_s1[4] <= in_word.rot_a_x * in_word.rot_b_y;
			cp_s1[5] <= in_word.rot_a_y * in_word.rot_b_x;
			w_s2 <= w_s1;
			c_s2 <= c_next;
			for (int j = 0; j < 3; j++) begin
				tp_s3[j][0] <= w_s2.point_x * a_v[j];
				tp_s3[j][1] <= w_s2.point_y * b_v[j];
				tp_s3[j][2] <= w_s2.point_z * c_s2[j];
			end
			t_s3[0] <= w_s2.shift_x;
			t_s3[1] <= w_s2.shift_y;
			t_s3[2] <= w_s2.shift_z;
			p_s4.x <= sat32(72'(sum[0]));
			p_s4.y <= sat32(72'(sum[1]));
			p_s4.z <= sat32(72'(sum[2]));
		end
	end

	assign out_valid = vld_s4;
	assign out_p = p_s4;

endmodule
`default_nettype wire

[design/ppp_div.sv]
// pipelined restoring divider, one quotient bit per stage, two lanes
`default_nettype none
module ppp_div import ppp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    in_valid,
	input  wire vec3_t   in_p,
	output logic         out_valid,
	output div_tag_t     out_tag,
	output logic [31+FRAC_BITS:0] q_x,
	output logic [31+FRAC_BITS:0] q_y
);

	localparam int DW = 32 + FRAC_BITS;

	logic           vld_s [DW+1];
	div_tag_t       tag_s [DW+1];
	logic [31:0]    dsor_s [DW+1];
	logic [31:0]    remx_s [DW+1];
	logic [31:0]    remy_s [DW+1];
	logic [DW-1:0]  wx_s [DW+1];
	logic [DW-1:0]  wy_s [DW+1];

	always_comb begin
		vld_s[0] = in_valid;
		tag_s[0].zero = (in_p.z == 32'sd0);
		tag_s[0].neg_x = in_p.x[31] ^ in_p.z[31];
		tag_s[0].neg_y = in_p.y[31] ^ in_p.z[31];
		dsor_s[0] = abs32(in_p.z);
		remx_s[0] = '0;
		remy_s[0] = '0;
		wx_s[0] = {abs32(in_p.x), {FRAC_BITS{1'b0}}};
		wy_s[0] = {abs32(in_p.y), {FRAC_BITS{1'b0}}};
	end

	for (genvar k = 1; k <= DW; k++) begin : g_stage
		logic [32:0] tx, ty, dx, dy;
		logic gex, gey;

		always_comb begin
			tx = {remx_s[k-1], wx_s[k-1][DW-1]};
			ty = {remy_s[k-1], wy_s[k-1][DW-1]};
			dx = tx - {1'b0, dsor_s[k-1]};
			dy = ty - {1'b0, dsor_s[k-1]};
			gex = (tx >= {1'b0, dsor_s[k-1]});
			gey = (ty >= {1'b0, dsor_s[k-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= tag_s[k-1];
				dsor_s[k] <= dsor_s[k-1];
				remx_s[k] <= gex ? dx[31:0] : tx[31:0];
				remy_s[k] <= gey ? dy[31:0] : ty[31:0];
				wx_s[k] <= {wx_s[k-1][DW-2:0], gex};
				wy_s[k] <= {wy_s[k-1][DW-2:0], gey};
			end
		end
	end

	assign out_valid = vld_s[DW];
	assign out_tag = tag_s[DW];
	assign q_x = wx_s[DW];
	assign q_y = wy_s[DW];

endmodule
`default_nettype wire

[design/ppp_cam.sv]
// quotient saturation, camera matrix and pixel scaling stages
`default_nettype none
module ppp_cam import ppp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_valid,
	input  wire div_tag_t in_tag,
	input  wire logic [31+FRAC_BITS:0] q_x,
	input  wire logic [31+FRAC_BITS:0] q_y,
	input  wire cam_cfg_t cfg,
	output logic          out_valid,
	output pixel_word_t   out_word
);

	localparam int DW = 32 + FRAC_BITS;
	localparam logic signed [63:0] BIAS = (64'sd1 <<< (2 * FRAC_BITS)) - 64'sd1;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	div_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [31:0] nx_s1, ny_s1;
	logic signed [63:0] m_s2 [4];
	logic signed [31:0] u_s3, w_s3;
	logic signed [63:0] pu_s4, pw_s4;
	pixel_word_t word_s5;

	logic signed [31:0] nx, ny, u_next, w_next;
	logic signed [63:0] tu, tw;
	logic signed [15:0] sx, sy;

	function automatic logic signed [31:0] qsat(input logic [DW-1:0] mag, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			if ((|mag[DW-1:32]) || (mag[31] && (|mag[30:0])))
				r = 32'sh80000000;
			else
				r = -signed'(mag[31:0]);
		end else begin
			if (|mag[DW-1:31])
				r = 32'sh7fffffff;
			else
				r = signed'(mag[31:0]);
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
		logic signed [15:0] r;
		if (x > 64'sd32767)
			r = 16'sh7fff;
		else if (x < -64'sd32768)
			r = 16'sh8000;
		else
			r = x[15:0];
		return r;
	endfunction

	always_comb begin
		nx = qsat(q_x, in_tag.neg_x);
		ny = qsat(q_y, in_tag.neg_y);
		u_next = sat32(72'(66'(m_s2[0] >>> FRAC_BITS) + 66'(m_s2[1] >>> FRAC_BITS)
			+ 66'(cfg.k02)));
		w_next = sat32(72'(66'(m_s2[2] >>> FRAC_BITS) + 66'(m_s2[3] >>> FRAC_BITS)
			+ 66'(cfg.k12)));
		tu = (pu_s4[63] ? pu_s4 + BIAS : pu_s4) >>> (2 * FRAC_BITS);
		tw = (pw_s4[63] ? pw_s4 + BIAS : pw_s4) >>> (2 * FRAC_BITS);
		sx = sat16(tu);
		sy = sat16(tw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			nx_s1 <= nx;
			ny_s1 <= ny;
			tag_s2 <= tag_s1;
			m_s2[0] <= cfg.k00 * nx_s1;
			m_s2[1] <= cfg.k01 * ny_s1;
			m_s2[2] <= cfg.k10 * nx_s1;
			m_s2[3] <= cfg.k11 * ny_s1;
			tag_s3 <= tag_s2;
			u_s3 <= u_next;
			w_s3 <= w_next;
			tag_s4 <= tag_s3;
			pu_s4 <= u_s3 * signed'({1'b0, cfg.scale_x});
			pw_s4 <= w_s3 * signed'({1'b0, cfg.scale_y});
			if (tag_s4.zero) begin
				word_s5 <= '0;
			end else begin
				word_s5.pixel_x <= sx;
				word_s5.pixel_y <= sy;
				word_s5.valid_res <= 1'b1;
			end
		end
	end

	assign out_valid = vld_s5;
	assign out_word = word_s5;

endmodule
`default_nettype wire

[design/pose_point_projection.sv]
// top level: register port, transform, divider and camera pipeline
//
//   channel   direction  handshake                  word
//   point     in         point_valid / point_stall  point_word_t
//   pixel     out        pixel_valid / pixel_stall  pixel_word_t
//   config    in         apb write / read           32-bit registers
//
// one word per cycle unless a stalled pixel word freezes the pipeline; points pass through
// the transform, the one-bit-per-stage divider and the camera stages in that order
// reset clears all valid bits and loads register defaults
// a stalled pixel word freezes the whole pipeline and stalls the point side
`default_nettype none
module pose_point_projection import ppp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              point_valid,
	output logic                   point_stall,
	input  wire point_word_t       point_word,
	output logic                   pixel_valid,
	input  wire logic              pixel_stall,
	output pixel_word_t            pixel_word,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	cam_cfg_t cfg_q;
	logic en;
	reg_idx_t idx;
	logic xf_valid, dv_valid;
	vec3_t xf_p;
	div_tag_t dv_tag;
	logic [31+FRAC_BITS:0] dv_qx, dv_qy;

	assign en = !(pixel_valid && pixel_stall);
	assign point_stall = !en;
	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k00 <= ONE;
			cfg_q.k01 <= '0;
			cfg_q.k02 <= '0;
			cfg_q.k10 <= '0;
			cfg_q.k11 <= ONE;
			cfg_q.k12 <= '0;
			cfg_q.scale_x <= ONE[30:0];
			cfg_q.scale_y <= ONE[30:0];
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_K00: cfg_q.k00 <= pwdata;
				REG_K01: cfg_q.k01 <= pwdata;
				REG_K02: cfg_q.k02 <= pwdata;
				REG_K10: cfg_q.k10 <= pwdata;
				REG_K11: cfg_q.k11 <= pwdata;
				REG_K12: cfg_q.k12 <= pwdata;
				REG_SCALE_X: cfg_q.scale_x <= pwdata[30:0];
				REG_SCALE_Y: cfg_q.scale_y <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_K00: prdata = cfg_q.k00;
			REG_K01: prdata = cfg_q.k01;
			REG_K02: prdata = cfg_q.k02;
			REG_K10: prdata = cfg_q.k10;
			REG_K11: prdata = cfg_q.k11;
			REG_K12: prdata = cfg_q.k12;
			REG_SCALE_X: prdata = {1'b0, cfg_q.scale_x};
			REG_SCALE_Y: prdata = {1'b0, cfg_q.scale_y};
			default: prdata = '0;
		endcase
	end

	ppp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(point_valid),
		.in_word(point_word),
		.out_valid(xf_valid),
		.out_p(xf_p)
	);

	ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(xf_valid),
		.in_p(xf_p),
		.out_valid(dv_valid),
		.out_tag(dv_tag),
		.q_x(dv_qx),
		.q_y(dv_qy)
	);

	ppp_cam #(.FRAC_BITS(FRAC_BITS)) u_cam (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(dv_valid),
		.in_tag(dv_tag),
		.q_x(dv_qx),
		.q_y(dv_qy),
		.cfg(cfg_q),
		.out_valid(pixel_valid),
		.out_word(pixel_word)
	);

endmodule
`default_nettype wire
